// File: rtl/tpr_pkg.sv
// Shared types, constants and coefficient table for the tangent pipeline.
package tpr_pkg;

  localparam int ANGLE_FRAC_BITS = 29;
  localparam int OUT_FRAC_BITS   = 16;
  localparam int WF              = 30;
  localparam int XIN_W           = 32 + WF - ANGLE_FRAC_BITS;
  localparam int P_W             = WF + 1;
  localparam int HORNER_N        = 5;
  localparam int DIV_W           = 2 * WF + 1;
  localparam int RSH             = WF - OUT_FRAC_BITS;
  localparam int MAG_W           = DIV_W + 1 - RSH;

  localparam logic [32:0] TWOPI_Q = 33'd6746518852;
  localparam logic [31:0] PI_Q    = 32'd3373259426;
  localparam logic [30:0] PI2_Q   = 31'd1686629713;
  localparam logic [29:0] PI4_Q   = 30'd843314857;
  localparam logic [P_W-1:0] ONE_Q = P_W'(64'd1 << WF);

  typedef struct packed {
    logic [31:0] angle;
    logic        last_in;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] tangent;
    logic               saturated;
    logic               last_out;
  } item_out_t;

  typedef struct packed {
    logic flip;
    logic shift;
    logic last;
  } side_t;

  typedef struct packed {
    logic flip;
    logic inf;
    logic last;
  } tag_t;

  typedef struct packed {
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] q;
    logic [DIV_W-1:0] n;
    logic [DIV_W-1:0] d;
  } div_st_t;

  function automatic logic [29:0] coef(input logic [2:0] k);
    logic [29:0] c;
    case (k)
      3'd0:    c = 30'd357911869;
      3'd1:    c = 30'd143228998;
      3'd2:    c = 30'd57309961;
      3'd3:    c = 30'd26376564;
      3'd4:    c = 30'd3114415;
      3'd5:    c = 30'd10218596;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tpr_reduce.sv
// Range reduction of the angle to [0, pi/4] in four register stages.
module tpr_reduce (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_vld_i,
  input  tpr_pkg::item_in_t       in_i,
  output logic                    out_vld_o,
  output logic [tpr_pkg::WF-1:0]  x_o,
  output tpr_pkg::side_t          side_o
);
  import tpr_pkg::*;

  logic [3:0]       vld_q;
  logic [XIN_W-1:0] xin;
  logic [32:0]      x1_d, x1_q;
  logic [31:0]      x2_d, x2_q;
  logic [30:0]      x3_d, x3_q;
  logic [29:0]      x4_d, x4_q;
  logic             last1_q, last2_q, last3_q;
  logic             flip3_d, flip3_q;
  side_t            side4_d, side4_q;

  assign xin = XIN_W'(in_i.angle) << (WF - ANGLE_FRAC_BITS);

  always_comb begin
    x1_d = (xin > XIN_W'(TWOPI_Q)) ? TWOPI_Q : xin[32:0];
    x2_d = (x1_q > 33'(PI_Q)) ? 32'(x1_q - 33'(PI_Q)) : x1_q[31:0];
    flip3_d = x2_q > 32'(PI2_Q);
    x3_d = flip3_d ? 31'(x2_q - 32'(PI2_Q)) : x2_q[30:0];
    side4_d.flip  = flip3_q;
    side4_d.last  = last3_q;
    side4_d.shift = x3_q > 31'(PI4_Q);
    x4_d = side4_d.shift ? 30'(x3_q - 31'(PI4_Q)) : x3_q[29:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x1_d;
    last1_q <= in_i.last_in;
    x2_q    <= x2_d;
    last2_q <= last1_q;
    x3_q    <= x3_d;
    flip3_q <= flip3_d;
    last3_q <= last2_q;
    x4_q    <= x4_d;
    side4_q <= side4_d;
  end

  assign out_vld_o = vld_q[3];
  assign x_o       = x4_q;
  assign side_o    = side4_q;

endmodule

// File: rtl/tpr_poly.sv
// Odd tangent polynomial by Horner's rule, one multiply per stage.
module tpr_poly (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_vld_i,
  input  logic [tpr_pkg::WF-1:0]  x_i,
  input  tpr_pkg::side_t          side_i,
  output logic                    out_vld_o,
  output logic [tpr_pkg::P_W-1:0] t_o,
  output tpr_pkg::side_t          side_o
);
  import tpr_pkg::*;

  logic                  sq_vld_q;
  logic [WF-1:0]         sq_x_q, sq_x2_q, sq_x2_d;
  side_t                 sq_side_q;
  logic [2*WF-1:0]       sq_prod;

  logic                  h_vld_q [HORNER_N];
  logic [WF-1:0]         h_x_q   [HORNER_N];
  logic [WF-1:0]         h_x2_q  [HORNER_N];
  logic [P_W-1:0]        h_p_q   [HORNER_N];
  logic [P_W-1:0]        h_p_d   [HORNER_N];
  side_t                 h_side_q[HORNER_N];
  logic [P_W-1:0]        h_p_in  [HORNER_N];
  logic [WF-1:0]         h_x2_in [HORNER_N];
  logic [WF+P_W-1:0]     h_prod  [HORNER_N];

  logic                  f_vld_q;
  logic [WF-1:0]         f_x_q;
  logic [P_W-1:0]        f_p_q, f_p_d;
  side_t                 f_side_q;
  logic [WF+P_W-1:0]     f_prod;

  logic                  t_vld_q;
  logic [P_W-1:0]        t_q, t_d;
  side_t                 t_side_q;
  logic [WF+P_W-1:0]     t_prod;

  assign sq_prod = x_i * x_i;
  assign sq_x2_d = sq_prod[2*WF-1:WF];

  always_comb begin
    for (int i = 0; i < HORNER_N; i++) begin
      if (i == 0) begin
        h_p_in[i]  = P_W'(coef(3'(HORNER_N)));
        h_x2_in[i] = sq_x2_q;
      end else begin
        h_p_in[i]  = h_p_q[i-1];
        h_x2_in[i] = h_x2_q[i-1];
      end
      h_prod[i] = h_x2_in[i] * h_p_in[i];
      h_p_d[i]  = P_W'(coef(3'(HORNER_N - 1 - i))) + P_W'(h_prod[i] >> WF);
    end
    f_prod = h_x2_q[HORNER_N-1] * h_p_q[HORNER_N-1];
    f_p_d  = ONE_Q + P_W'(f_prod >> WF);
    t_prod = f_x_q * f_p_q;
    t_d    = P_W'(t_prod >> WF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      f_vld_q  <= 1'b0;
      t_vld_q  <= 1'b0;
      for (int i = 0; i < HORNER_N; i++) begin
        h_vld_q[i] <= 1'b0;
      end
    end else begin
      sq_vld_q <= in_vld_i;
      for (int i = 0; i < HORNER_N; i++) begin
        h_vld_q[i] <= (i == 0) ? sq_vld_q : h_vld_q[(i == 0) ? 0 : i-1];
      end
      f_vld_q <= h_vld_q[HORNER_N-1];
      t_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_x_q    <= x_i;
    sq_x2_q   <= sq_x2_d;
    sq_side_q <= side_i;
    for (int i = 0; i < HORNER_N; i++) begin
      h_p_q[i]    <= h_p_d[i];
      h_x2_q[i]   <= h_x2_in[i];
      h_x_q[i]    <= (i == 0) ? sq_x_q : h_x_q[(i == 0) ? 0 : i-1];
      h_side_q[i] <= (i == 0) ? sq_side_q : h_side_q[(i == 0) ? 0 : i-1];
    end
    f_x_q    <= h_x_q[HORNER_N-1];
    f_p_q    <= f_p_d;
    f_side_q <= h_side_q[HORNER_N-1];
    t_q      <= t_d;
    t_side_q <= f_side_q;
  end

  assign out_vld_o = t_vld_q;
  assign t_o       = t_q;
  assign side_o    = t_side_q;

endmodule

// File: rtl/tpr_div.sv
// Restoring divider pipeline, one quotient bit per stage.
module tpr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_vld_i,
  input  logic [tpr_pkg::DIV_W-1:0] num_i,
  input  logic [tpr_pkg::DIV_W-1:0] den_i,
  input  tpr_pkg::tag_t             tag_i,
  output logic                      out_vld_o,
  output logic [tpr_pkg::DIV_W-1:0] quo_o,
  output tpr_pkg::tag_t             tag_o
);
  import tpr_pkg::*;

  div_st_t          st_in  [DIV_W];
  div_st_t          st_d   [DIV_W];
  div_st_t          st_q   [DIV_W];
  tag_t             tag_q  [DIV_W];
  logic             vld_q  [DIV_W];
  logic [DIV_W:0]   rem_sh [DIV_W];
  logic [DIV_W:0]   rem_df [DIV_W];

  always_comb begin
    for (int i = 0; i < DIV_W; i++) begin
      if (i == 0) begin
        st_in[i].r = '0;
        st_in[i].q = '0;
        st_in[i].n = num_i;
        st_in[i].d = den_i;
      end else begin
        st_in[i] = st_q[i-1];
      end
      rem_sh[i] = {st_in[i].r, st_in[i].n[DIV_W-1]};
      rem_df[i] = rem_sh[i] - {1'b0, st_in[i].d};
      st_d[i].d = st_in[i].d;
      st_d[i].n = {st_in[i].n[DIV_W-2:0], 1'b0};
      if (!rem_df[i][DIV_W]) begin
        st_d[i].r = rem_df[i][DIV_W-1:0];
        st_d[i].q = {st_in[i].q[DIV_W-2:0], 1'b1};
      end else begin
        st_d[i].r = rem_sh[i][DIV_W-1:0];
        st_d[i].q = {st_in[i].q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_W; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < DIV_W; i++) begin
        vld_q[i] <= (i == 0) ? in_vld_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIV_W; i++) begin
      st_q[i]  <= st_d[i];
      tag_q[i] <= (i == 0) ? tag_i : tag_q[(i == 0) ? 0 : i-1];
    end
  end

  assign out_vld_o = vld_q[DIV_W-1];
  assign quo_o     = st_q[DIV_W-1].q;
  assign tag_o     = tag_q[DIV_W-1];

endmodule

// File: rtl/tangent_poly_range_reduced.sv
// Top level: tangent of a Q3.29 angle as saturated Q16.16, fully pipelined.
// Usage: the block takes one item in every cycle (busy_o stays low) and shows
// each result on res_o for one cycle with done_o high, in input order. The
// pipeline is made up mostly of the two restoring divider pipelines of 61
// stages each (quarter rebuild and inversion), plus four reduction stages,
// eight polynomial multiply stages and three setup and rounding stages. The
// receiver cannot stall the block.
module tangent_poly_range_reduced (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tpr_pkg::item_in_t   in_i,
  output logic                busy_o,
  output logic                done_o,
  output tpr_pkg::item_out_t  res_o
);
  import tpr_pkg::*;

  logic              acc;
  logic              red_vld;
  logic [WF-1:0]     red_x;
  side_t             red_side;
  logic              poly_vld;
  logic [P_W-1:0]    poly_t;
  side_t             poly_side;

  logic              p1_vld_q;
  logic [DIV_W-1:0]  p1_num_d, p1_num_q, p1_den_d, p1_den_q;
  tag_t              p1_tag_d, p1_tag_q;

  logic              d1_vld;
  logic [DIV_W-1:0]  d1_quo;
  tag_t              d1_tag;

  logic              p2_vld_q;
  logic [DIV_W-1:0]  p2_num_d, p2_num_q, p2_den_d, p2_den_q;
  tag_t              p2_tag_d, p2_tag_q;

  logic              d2_vld;
  logic [DIV_W-1:0]  d2_quo;
  tag_t              d2_tag;

  logic [DIV_W:0]    rnd_sum;
  logic [MAG_W-1:0]  mag;
  item_out_t         res_d, res_q;
  logic              done_q;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  tpr_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (acc),
    .in_i      (in_i),
    .out_vld_o (red_vld),
    .x_o       (red_x),
    .side_o    (red_side)
  );

  tpr_poly u_poly (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (red_vld),
    .x_i       (red_x),
    .side_i    (red_side),
    .out_vld_o (poly_vld),
    .t_o       (poly_t),
    .side_o    (poly_side)
  );

  always_comb begin
    p1_tag_d.flip = poly_side.flip;
    p1_tag_d.last = poly_side.last;
    p1_tag_d.inf  = poly_side.shift && (poly_t >= ONE_Q);
    p1_den_d      = DIV_W'(1);
    if (!poly_side.shift) begin
      p1_num_d = DIV_W'(poly_t);
    end else if (p1_tag_d.inf) begin
      p1_num_d = '0;
    end else begin
      p1_num_d = {P_W'(poly_t + ONE_Q), {WF{1'b0}}};
      p1_den_d = DIV_W'(ONE_Q - poly_t);
    end
  end

  tpr_div u_div_rebuild (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (p1_vld_q),
    .num_i     (p1_num_q),
    .den_i     (p1_den_q),
    .tag_i     (p1_tag_q),
    .out_vld_o (d1_vld),
    .quo_o     (d1_quo),
    .tag_o     (d1_tag)
  );

  always_comb begin
    p2_tag_d = d1_tag;
    p2_den_d = DIV_W'(1);
    p2_num_d = d1_quo;
    if (d1_tag.flip) begin
      if (d1_tag.inf) begin
        p2_tag_d.inf = 1'b0;
        p2_num_d     = '0;
      end else if (d1_quo == '0) begin
        p2_tag_d.inf = 1'b1;
        p2_num_d     = '0;
      end else begin
        p2_num_d = DIV_W'(1) << (2 * WF);
        p2_den_d = d1_quo;
      end
    end
  end

  tpr_div u_div_invert (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (p2_vld_q),
    .num_i     (p2_num_q),
    .den_i     (p2_den_q),
    .tag_i     (p2_tag_q),
    .out_vld_o (d2_vld),
    .quo_o     (d2_quo),
    .tag_o     (d2_tag)
  );

  always_comb begin
    rnd_sum = {1'b0, d2_quo} + ((DIV_W + 1)'(1) << (RSH - 1));
    mag     = rnd_sum[DIV_W:RSH];
    res_d.last_out  = d2_tag.last;
    res_d.saturated = 1'b0;
    if (d2_tag.inf) begin
      res_d.saturated = 1'b1;
      res_d.tangent   = d2_tag.flip ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (d2_tag.flip) begin
      if (mag > MAG_W'(64'h8000_0000)) begin
        res_d.saturated = 1'b1;
        res_d.tangent   = 32'sh8000_0000;
      end else begin
        res_d.tangent = 32'(32'd0 - mag[31:0]);
      end
    end else begin
      if (mag > MAG_W'(64'h7FFF_FFFF)) begin
        res_d.saturated = 1'b1;
        res_d.tangent   = 32'sh7FFF_FFFF;
      end else begin
        res_d.tangent = mag[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p1_vld_q <= poly_vld;
      p2_vld_q <= d1_vld;
      done_q   <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_num_q <= p1_num_d;
    p1_den_q <= p1_den_d;
    p1_tag_q <= p1_tag_d;
    p2_num_q <= p2_num_d;
    p2_den_q <= p2_den_d;
    p2_tag_q <= p2_tag_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated && !res_o.tangent[31] |-> res_o.tangent == 32'sh7FFF_FFFF)
    else $error("positive saturation value wrong");

  a_neg_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated && res_o.tangent[31] |-> res_o.tangent == 32'sh8000_0000)
    else $error("negative saturation value wrong");

  a_pole_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_vld && d1_tag.inf |-> d1_quo == '0)
    else $error("pole item carries nonzero quotient");

endmodule

// File: bench/tangent_poly_range_reduced_tb.sv
// Testbench for the tangent pipeline: directed table plus random angles, checked against a predictor.
module tangent_poly_range_reduced_tb;
  import tpr_pkg::*;

  localparam int unsigned QPI4  = 32'd421657428;
  localparam int unsigned QPI2  = 32'd843314856;
  localparam int unsigned QPI   = 32'd1686629713;
  localparam int unsigned Q3PI2 = 32'd2529944570;
  localparam int unsigned Q2PI  = 32'd3373259426;
  localparam int          N_RANDOM = 2000;
  localparam int          DRAIN    = 160;

  typedef struct {
    logic [31:0] angle;
    logic        last;
    bit          known;
    item_out_t   res;
  } vec_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  item_in_t  in_i = '0;
  logic      busy_o;
  logic      done_o;
  item_out_t res_o;

  item_out_t tan_q[$];
  int        n_err = 0;
  vec_t      dir_tab[$];

  tangent_poly_range_reduced u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned coef_q30(input longint unsigned d);
    return (d * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
  endfunction

  function automatic longint unsigned horner_tan(input longint unsigned x);
    longint unsigned c[6];
    longint unsigned x2;
    longint unsigned p;
    c[0] = coef_q30(64'd3333314036);
    c[1] = coef_q30(64'd1333923995);
    c[2] = coef_q30(64'd533740603);
    c[3] = coef_q30(64'd245650893);
    c[4] = coef_q30(64'd29005250);
    c[5] = coef_q30(64'd95168091);
    x2 = (x * x) >> 30;
    p = c[5];
    for (int k = 4; k >= 0; k--) begin
      p = c[k] + ((x2 * p) >> 30);
    end
    p = (64'd1 << 30) + ((x2 * p) >> 30);
    return (x * p) >> 30;
  endfunction

  function automatic item_out_t tan_predict(input logic [31:0] angle, input logic last);
    longint unsigned x;
    longint unsigned t;
    longint unsigned u;
    longint unsigned mag;
    longint unsigned one;
    bit flip;
    bit shift;
    bit inf;
    bit neg;
    item_out_t r;
    one = 64'd1 << 30;
    flip = 0;
    shift = 0;
    inf = 0;
    neg = 0;
    u = 0;
    x = longint'(angle) << 1;
    if (x > 64'd6746518852) x = 64'd6746518852;
    if (x > 64'd3373259426) x -= 64'd3373259426;
    if (x > 64'd1686629713) begin
      x -= 64'd1686629713;
      flip = 1;
    end
    if (x > 64'd843314857) begin
      x -= 64'd843314857;
      shift = 1;
    end
    t = horner_tan(x);
    if (shift) begin
      if (t >= one) inf = 1;
      else u = ((t + one) << 30) / (one - t);
    end else begin
      u = t;
    end
    if (flip) begin
      neg = 1;
      if (inf) begin
        inf = 0;
        u = 0;
      end else if (u == 0) begin
        inf = 1;
      end else begin
        u = (64'd1 << 60) / u;
      end
    end
    r.last_out = last;
    r.saturated = 1'b0;
    if (inf) begin
      r.saturated = 1'b1;
      r.tangent = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      mag = (u + (64'd1 << 13)) >> 14;
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          r.saturated = 1'b1;
          mag = 64'h8000_0000;
        end
        r.tangent = 32'd0 - mag[31:0];
      end else begin
        if (mag > 64'h7FFF_FFFF) begin
          r.saturated = 1'b1;
          mag = 64'h7FFF_FFFF;
        end
        r.tangent = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_angle();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(99);
    if (pick < 45) return $urandom_range(Q2PI);
    if (pick < 60) return $urandom;
    case ($urandom_range(5))
      0: base = 0;
      1: base = QPI4;
      2: base = QPI2;
      3: base = QPI;
      4: base = Q3PI2;
      default: base = Q2PI;
    endcase
    return base + $urandom_range(64) - 32;
  endfunction

  function automatic void add_row(input logic [31:0] a, input logic l, input bit k,
                                  input item_out_t r);
    vec_t v;
    v.angle = a;
    v.last = l;
    v.known = k;
    v.res = r;
    dir_tab.push_back(v);
  endfunction

  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      tan_q.push_back(tan_predict(in_i.angle, in_i.last_in));
    end
    if (done_o) begin
      if (tan_q.size() == 0) begin
        $display("%0t: unexpected result tangent=%h saturated=%b last=%b", $time,
                 res_o.tangent, res_o.saturated, res_o.last_out);
        n_err++;
      end else begin
        item_out_t e;
        e = tan_q.pop_front();
        if (res_o.tangent !== e.tangent) begin
          $display("%0t: tangent expected %h actual %h", $time, e.tangent, res_o.tangent);
          n_err++;
        end
        if (res_o.saturated !== e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                   res_o.saturated);
          n_err++;
        end
        if (res_o.last_out !== e.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time, e.last_out,
                   res_o.last_out);
          n_err++;
        end
      end
    end
  end

  task automatic send_item(input logic [31:0] a, input logic l, input bit k,
                           input item_out_t r);
    start_i <= 1'b1;
    in_i.angle <= a;
    in_i.last_in <= l;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    if (k && tan_predict(a, l) !== r) begin
      $display("%0t: table row %h expected %h actual %h", $time, a, r,
               tan_predict(a, l));
      n_err++;
    end
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    item_out_t zero_res;
    item_out_t none;
    int burst;
    zero_res = '0;
    none = '0;
    add_row(32'd0, 1'b0, 1, zero_res);
    add_row(32'd0, 1'b1, 1, '{tangent: 32'sd0, saturated: 1'b0, last_out: 1'b1});
    add_row(32'd1, 1'b0, 0, none);
    add_row(QPI4 - 1, 1'b0, 0, none);
    add_row(QPI4, 1'b1, 0, none);
    add_row(QPI4 + 1, 1'b0, 0, none);
    add_row(QPI2 - 1, 1'b0, 0, none);
    add_row(QPI2, 1'b0, 0, none);
    add_row(QPI2 + 1, 1'b1, 0, none);
    add_row(QPI2 + 2, 1'b0, 0, none);
    add_row(QPI - 1, 1'b0, 0, none);
    add_row(QPI, 1'b0, 0, none);
    add_row(QPI + 1, 1'b1, 0, none);
    add_row(Q3PI2, 1'b0, 0, none);
    add_row(Q3PI2 + 1, 1'b0, 0, none);
    add_row(Q2PI - 1, 1'b0, 0, none);
    add_row(Q2PI, 1'b1, 0, none);
    add_row(Q2PI + 1, 1'b0, 0, none);
    add_row(32'hFFFF_FFFF, 1'b1, 0, none);
    add_row(32'h8000_0000, 1'b0, 0, none);
    add_row(32'h5555_5555, 1'b1, 0, none);
    add_row(32'h2AAA_AAAA, 1'b0, 0, none);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].angle, dir_tab[i].last, dir_tab[i].known, dir_tab[i].res);
      if ($urandom_range(3) == 0) pause_sender($urandom_range(1, 4));
    end

    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      send_item(rand_angle(), 1'($urandom_range(1)), 0, none);
      if (i == N_RANDOM / 2) begin
        start_i <= 1'b0;
        wait (tan_q.size() == 0);
        @(posedge clk_i);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (i > N_RANDOM / 4 && i < N_RANDOM / 3) pause_sender(0);
        else pause_sender($urandom_range(0, 12));
      end else begin
        burst--;
      end
    end
    start_i <= 1'b0;
    wait (tan_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
